[hw/rtl/hspl_pkg.sv]
// Package for the H.264 Annex B SPS/PPS locator.
// Holds the NAL type codes, start code pattern, flag struct and output limits.
// No dependencies.
package hspl_pkg;

   // NAL unit type codes, taken from the low five bits of the header byte
   localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
   localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

   // Start code 00 00 01 and the window value after reset
   localparam logic [23:0] START_CODE   = 24'h000001;
   localparam logic [15:0] WINDOW_RESET = 16'h00FF;

   // A unit is reported from its start code, four bytes before the header
   localparam int HEADER_BACKOFF = 4;

   // Saturation limits of the result fields
   localparam logic [15:0] OFFSET_MAX = 16'hFFFF;
   localparam logic [16:0] LENGTH_MAX = 17'h1FFFF;

   // Units seen so far, plus the overlong buffer flag
   typedef struct packed {
      logic overflow;
      logic idr;
      logic pps;
      logic sps;
   } hspl_flags_type;

endpackage

[hw/rtl/hspl_scan.sv]
// Byte scanner: start code window, NAL header classification and position tracking.
// Depends on hspl_pkg. Outputs are the updated state for the byte in the input register.
module hspl_scan
   import hspl_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = 65536,
   parameter int CW = $clog2(MAX_BUFFER_BYTES + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   output logic [CW-1:0]  count_in,
   output logic [CW-1:0]  sps_start_in,
   output logic [CW-1:0]  pps_start_in,
   output logic [CW-1:0]  idr_start_in,
   output hspl_flags_type flags_in
);

   localparam logic [CW-1:0] MaxCount = CW'(MAX_BUFFER_BYTES);
   localparam logic [CW-1:0] Backoff  = CW'(HEADER_BACKOFF);

   logic [15:0]    window_ff;
   logic [15:0]    window_in;
   logic           pending_ff;
   logic           pending_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  start_ff;
   logic [CW-1:0]  start_in;
   logic [CW-1:0]  sps_start_ff;
   logic [CW-1:0]  pps_start_ff;
   logic [CW-1:0]  idr_start_ff;
   hspl_flags_type flags_ff;
   logic [23:0]    window24;
   logic [4:0]     nal_type;

   // Next state for one byte; start_ff tracks the byte index less four, floored at zero
   always_comb begin
      window24     = {window_ff, data_byte};
      nal_type     = data_byte[4:0];
      sps_start_in = sps_start_ff;
      pps_start_in = pps_start_ff;
      idr_start_in = idr_start_ff;
      flags_in     = flags_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      // classify the byte after a start code; a later unit overwrites an earlier one
      if (pending_ff) begin
         case (nal_type)
            NAL_TYPE_IDR: begin
               idr_start_in = start_ff;
               flags_in.idr = 1'b1;
            end
            NAL_TYPE_SPS: begin
               sps_start_in = start_ff;
               flags_in.sps = 1'b1;
            end
            NAL_TYPE_PPS: begin
               pps_start_in = start_ff;
               flags_in.pps = 1'b1;
            end
            default: begin
            end
         endcase
      end
      window_in  = window24[15:0];
      pending_in = (window24 == START_CODE);
      // byte counter saturates at the buffer limit
      if (count_ff < MaxCount) begin
         count_in = count_ff + CW'(1);
         if (count_ff >= Backoff) begin
            start_in = start_ff + CW'(1);
         end
      end else begin
         flags_in.overflow = 1'b1;
      end
   end

   // State returns to reset after the last byte of a buffer
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         window_ff    <= WINDOW_RESET;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         start_ff     <= '0;
         sps_start_ff <= '0;
         pps_start_ff <= '0;
         idr_start_ff <= '0;
         flags_ff     <= '0;
      end else if (step) begin
         window_ff    <= window_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         sps_start_ff <= sps_start_in;
         pps_start_ff <= pps_start_in;
         idr_start_ff <= idr_start_in;
         flags_ff     <= flags_in;
      end
   end

endmodule

[hw/rtl/hspl_fmt.sv]
// Result formatter: unit lengths and saturation of offsets and lengths.
// Depends on hspl_pkg. Purely combinational; feeds the result register.
module hspl_fmt
   import hspl_pkg::*;
#(
   parameter int CW = 17
) (
   input  logic [CW-1:0]  count,
   input  logic [CW-1:0]  sps_start,
   input  logic [CW-1:0]  pps_start,
   input  logic [CW-1:0]  idr_start,
   input  hspl_flags_type flags,
   output logic [15:0]    sps_offset,
   output logic [16:0]    sps_length,
   output logic [15:0]    pps_offset,
   output logic [16:0]    pps_length
);

   localparam int EW = (CW > 17) ? CW : 17;

   logic [EW-1:0] sps_x;
   logic [EW-1:0] pps_x;
   logic [EW-1:0] end_x;
   logic [EW-1:0] sps_len_x;
   logic [EW-1:0] pps_len_x;

   // PPS runs to the IDR start code when one was seen, else to the end of the buffer
   always_comb begin
      sps_x = EW'(sps_start);
      pps_x = EW'(pps_start);
      end_x = flags.idr ? EW'(idr_start) : EW'(count);
      sps_len_x = (pps_x >= sps_x) ? (pps_x - sps_x) : '0;
      pps_len_x = (end_x >= pps_x) ? (end_x - pps_x) : '0;
   end

   // Saturate to the field widths
   assign sps_offset = (sps_x > EW'(OFFSET_MAX)) ? OFFSET_MAX : sps_x[15:0];
   assign pps_offset = (pps_x > EW'(OFFSET_MAX)) ? OFFSET_MAX : pps_x[15:0];
   assign sps_length = (sps_len_x > EW'(LENGTH_MAX)) ? LENGTH_MAX : sps_len_x[16:0];
   assign pps_length = (pps_len_x > EW'(LENGTH_MAX)) ? LENGTH_MAX : pps_len_x[16:0];

endmodule

[hw/rtl/h264_sps_pps_locator_core.sv]
// H.264 Annex B SPS/PPS locator, top level.
// Flow: a byte is taken into the input register, then updates the scan state and,
// if it is the last byte of a buffer, loads the result register.
// Throughput: one byte per cycle; stalls only while a last byte waits behind a result still
// held. Synchronous active-high reset clears the valid flags and the scan state.
// Depends on hspl_pkg, hspl_scan and hspl_fmt.
module h264_sps_pps_locator_core
   import hspl_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_sps_offset,
   output logic [16:0] rsp_sps_length,
   output logic [15:0] rsp_pps_offset,
   output logic [16:0] rsp_pps_length,
   output logic        rsp_sps_found,
   output logic        rsp_pps_found,
   output logic        rsp_too_long
);

   localparam int CW = $clog2(MAX_BUFFER_BYTES + 1);

   logic           s1_valid_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_last_ff;
   logic           out_free;
   logic           s1_advance;
   logic           req_take;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [CW-1:0]  count_in;
   logic [CW-1:0]  sps_start_in;
   logic [CW-1:0]  pps_start_in;
   logic [CW-1:0]  idr_start_in;
   hspl_flags_type flags_in;
   logic [15:0]    sps_offset_in;
   logic [16:0]    sps_length_in;
   logic [15:0]    pps_offset_in;
   logic [16:0]    pps_length_in;
   logic [15:0]    sps_offset_ff;
   logic [16:0]    sps_length_ff;
   logic [15:0]    pps_offset_ff;
   logic [16:0]    pps_length_ff;
   hspl_flags_type flags_ff;

   // Handshake: only a last byte needs room in the result register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   hspl_scan #(
      .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
      .CW(CW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_advance),
      .data_byte   (s1_byte_ff),
      .last_byte   (s1_last_ff),
      .count_in    (count_in),
      .sps_start_in(sps_start_in),
      .pps_start_in(pps_start_in),
      .idr_start_in(idr_start_in),
      .flags_in    (flags_in)
   );

   hspl_fmt #(
      .CW(CW)
   ) u_fmt (
      .count     (count_in),
      .sps_start (sps_start_in),
      .pps_start (pps_start_in),
      .idr_start (idr_start_in),
      .flags     (flags_in),
      .sps_offset(sps_offset_in),
      .sps_length(sps_length_in),
      .pps_offset(pps_offset_in),
      .pps_length(pps_length_in)
   );

   // Result register: loaded by the last byte, cleared once the transfer completes
   always_comb begin
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         sps_offset_ff <= sps_offset_in;
         sps_length_ff <= sps_length_in;
         pps_offset_ff <= pps_offset_in;
         pps_length_ff <= pps_length_in;
         flags_ff      <= flags_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sps_offset = sps_offset_ff;
   assign rsp_sps_length = sps_length_ff;
   assign rsp_pps_offset = pps_offset_ff;
   assign rsp_pps_length = pps_length_ff;
   assign rsp_sps_found  = flags_ff.sps;
   assign rsp_pps_found  = flags_ff.pps;
   assign rsp_too_long   = flags_ff.overflow;

   // A new result only appears after a last byte left the input register
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without a last byte");

   // A unit not seen reports offset zero
   a_missing_unit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_sps_found || !rsp_pps_found) |->
         ((rsp_sps_found || rsp_sps_offset == 16'd0) &&
          (rsp_pps_found || rsp_pps_offset == 16'd0)))
      else $error("offset of an unseen unit is not zero");

   // Input is held back only by a pending last byte behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid && rsp_stall))
      else $error("input stalled without cause");

endmodule

[verif/h264_sps_pps_locator_core_tb.sv]
// Self-checking testbench for h264_sps_pps_locator_core: directed table, a long receiver
// hold-off, random Annex B buffers under several idle and stall patterns, local predictor.
// Depends on hspl_pkg and the h264_sps_pps_locator_core RTL.
module h264_sps_pps_locator_core_tb;
   import hspl_pkg::*;

   localparam int SCAN_LIMIT     = 65536;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIR_N          = 28;
   localparam logic [16:0] BACKOFF = 17'(HEADER_BACKOFF);

   typedef struct packed {
      logic [15:0] sps_offset;
      logic [16:0] sps_length;
      logic [15:0] pps_offset;
      logic [16:0] pps_length;
      logic        sps_found;
      logic        pps_found;
      logic        too_long;
   } locator_report_type;

   // one byte transfer, with an optional hand-typed report for a last byte
   typedef struct packed {
      logic [7:0]         data;
      logic               last;
      logic               typed;
      locator_report_type report;
   } stim_type;

   localparam locator_report_type NO_REPORT = '0;

   // Directed buffers: lone 0xFF, start code as last byte, header as last byte,
   // SPS/PPS/IDR in order, PPS ahead of SPS
   localparam stim_type DIRECTED [0:DIR_N-1] = '{
      '{8'hFF, 1'b1, 1'b1, '{16'd0, 17'd0, 16'd0, 17'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h01, 1'b1, 1'b1, '{16'd0, 17'd0, 16'd0, 17'd3, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, 1'b0, NO_REPORT},
      '{8'h67, 1'b1, 1'b1, '{16'd0, 17'd0, 16'd0, 17'd4, 1'b1, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, 1'b0, NO_REPORT},
      '{8'h67, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, 1'b0, NO_REPORT},
      '{8'h68, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, 1'b0, NO_REPORT},
      '{8'h65, 1'b1, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, 1'b0, NO_REPORT},
      '{8'h68, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h00, 1'b0, 1'b0, NO_REPORT},
      '{8'h01, 1'b0, 1'b0, NO_REPORT},
      '{8'hE7, 1'b1, 1'b0, NO_REPORT}
   };

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [15:0] rsp_sps_offset;
   logic [16:0] rsp_sps_length;
   logic [15:0] rsp_pps_offset;
   logic [16:0] rsp_pps_length;
   logic        rsp_sps_found;
   logic        rsp_pps_found;
   logic        rsp_too_long;

   // travels with the payload so the monitor knows whether a row was hand-typed
   logic               req_report_typed = 1'b0;
   locator_report_type req_report_value = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_epoch    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int mismatch_count = 0;
   int bytes_sent    = 0;
   int buffers_sent  = 0;

   locator_report_type awaited_reports [$];

   // predictor copy of the scan state
   logic [23:0]    scan_window;
   logic           scan_header_next;
   logic [16:0]    scan_count;
   logic [16:0]    scan_sps_pos;
   logic [16:0]    scan_pps_pos;
   logic [16:0]    scan_idr_pos;
   hspl_flags_type scan_flags;

   h264_sps_pps_locator_core #(
      .MAX_BUFFER_BYTES(SCAN_LIMIT)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sps_offset(rsp_sps_offset),
      .rsp_sps_length(rsp_sps_length),
      .rsp_pps_offset(rsp_pps_offset),
      .rsp_pps_length(rsp_pps_length),
      .rsp_sps_found (rsp_sps_found),
      .rsp_pps_found (rsp_pps_found),
      .rsp_too_long  (rsp_too_long)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   task automatic scan_clear();
      scan_window      = {8'h00, WINDOW_RESET};
      scan_header_next = 1'b0;
      scan_count       = '0;
      scan_sps_pos     = '0;
      scan_pps_pos     = '0;
      scan_idr_pos     = '0;
      scan_flags       = '0;
   endtask

   function automatic logic [16:0] back_off(input logic [16:0] p);
      back_off = (p >= BACKOFF) ? p - BACKOFF : 17'd0;
   endfunction

   task automatic locate_step(input logic [7:0] b, input logic last,
                              output logic emitted, output locator_report_type rep);
      logic [16:0] pos;
      logic [16:0] sps_start;
      logic [16:0] pps_start;
      logic [16:0] span_end;
      pos     = scan_count;
      emitted = 1'b0;
      rep     = '0;
      // byte after a start code is the NAL header
      if (scan_header_next) begin
         case (b[4:0])
            NAL_TYPE_IDR: begin
               scan_idr_pos   = pos;
               scan_flags.idr = 1'b1;
            end
            NAL_TYPE_SPS: begin
               scan_sps_pos   = pos;
               scan_flags.sps = 1'b1;
            end
            NAL_TYPE_PPS: begin
               scan_pps_pos   = pos;
               scan_flags.pps = 1'b1;
            end
            default: ;
         endcase
         scan_header_next = 1'b0;
      end
      scan_window = {scan_window[15:0], b};
      if (scan_window == START_CODE) scan_header_next = 1'b1;
      // count saturates; anything past the limit marks the buffer overlong
      if (scan_count < SCAN_LIMIT) scan_count = scan_count + 17'd1;
      else scan_flags.overflow = 1'b1;
      if (last) begin
         sps_start = back_off(scan_sps_pos);
         pps_start = back_off(scan_pps_pos);
         span_end  = scan_flags.idr ? back_off(scan_idr_pos) : scan_count;
         rep.sps_offset = (sps_start > OFFSET_MAX) ? OFFSET_MAX : sps_start[15:0];
         rep.pps_offset = (pps_start > OFFSET_MAX) ? OFFSET_MAX : pps_start[15:0];
         // differences of 17-bit positions never exceed LENGTH_MAX
         rep.sps_length = (pps_start >= sps_start) ? pps_start - sps_start : 17'd0;
         rep.pps_length = (span_end >= pps_start) ? span_end - pps_start : 17'd0;
         rep.sps_found  = scan_flags.sps;
         rep.pps_found  = scan_flags.pps;
         rep.too_long   = scan_flags.overflow;
         emitted = 1'b1;
         scan_clear();
      end
   endtask

   // ---------------------------------------------------------------- checking
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_report(input locator_report_type want,
                               input locator_report_type got);
      check_field("sps_offset", want.sps_offset, got.sps_offset);
      check_field("sps_length", want.sps_length, got.sps_length);
      check_field("pps_offset", want.pps_offset, got.pps_offset);
      check_field("pps_length", want.pps_length, got.pps_length);
      check_field("sps_found", want.sps_found, got.sps_found);
      check_field("pps_found", want.pps_found, got.pps_found);
      check_field("too_long", want.too_long, got.too_long);
   endtask

   // Transfers on both channels, sampled at the rising edge
   always @(posedge clock) begin : monitor
      locator_report_type predicted;
      locator_report_type observed;
      logic               emitted;
      if (reset) begin
         scan_clear();
      end else begin
         if (req_valid && !req_stall) begin
            locate_step(req_data_byte, req_last_byte, emitted, predicted);
            if (emitted)
               awaited_reports.push_back(req_report_typed ? req_report_value : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            observed = '{rsp_sps_offset, rsp_sps_length, rsp_pps_offset, rsp_pps_length,
                         rsp_sps_found, rsp_pps_found, rsp_too_long};
            if (awaited_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none actual %h", $time, observed);
               mismatch_count++;
            end else begin
               check_report(awaited_reports.pop_front(), observed);
            end
         end
      end
   end

   // Watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("h264_sps_pps_locator_core_tb failed");
            $finish;
         end
      end
   end

   // Receiver: random stall, or a long hold-off when a new epoch is requested
   always @(negedge clock) begin
      if (hold_epoch != hold_seen) begin
         hold_seen <= hold_epoch;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus
   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input stim_type s);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= s.data;
      req_last_byte    <= s.last;
      req_report_typed <= s.typed;
      req_report_value <= s.report;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Set idle/stall pattern and hold between phases; writes kept off the falling edge
   task automatic set_mode(input int idle_pct, input int stall_pct, input bit hold);
      req_valid <= 1'b0;
      @(posedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold) hold_epoch++;
      @(negedge clock);
   endtask

   // Mostly well-formed unit sequences, some truncated, some byte noise
   task automatic send_random_buffer();
      logic [7:0] bytes [$];
      logic [2:0] nri;
      logic [4:0] nal;
      int         kind;
      int         cut;
      stim_type   s;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 1) bytes.push_back(8'h00);
            bytes.push_back(8'h00);
            bytes.push_back(8'h00);
            bytes.push_back(8'h01);
            nri = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 4))
               0: nal = NAL_TYPE_SPS;
               1: nal = NAL_TYPE_PPS;
               2: nal = NAL_TYPE_IDR;
               default: nal = 5'($urandom_range(0, 31));
            endcase
            bytes.push_back({nri, nal});
            repeat ($urandom_range(0, 6)) bytes.push_back(8'($urandom_range(0, 255)));
         end
         // broken sequence: cut anywhere, start code or header included
         if (kind == 6) begin
            cut = $urandom_range(1, bytes.size());
            while (bytes.size() > cut) void'(bytes.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: bytes.push_back(8'h00);
               4, 5:       bytes.push_back(8'h01);
               default:    bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      foreach (bytes[i]) begin
         s = '{bytes[i], i == bytes.size() - 1, 1'b0, NO_REPORT};
         send_item(s);
      end
      bytes_sent   += bytes.size();
      buffers_sent += 1;
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      int first_byte;
      int first_buffer;
      set_mode(idle_pct, stall_pct, 1'b0);
      first_byte   = bytes_sent;
      first_buffer = buffers_sent;
      while (bytes_sent - first_byte < 100 || buffers_sent - first_buffer < 6)
         send_random_buffer();
   endtask

   initial begin : stimulus
      stim_type s;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIR_N; i++) send_item(DIRECTED[i]);

      // receiver holds off while one-byte buffers keep coming, so the block backs up
      set_mode(0, 0, 1'b1);
      repeat (8) begin
         s = '{8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_REPORT};
         send_item(s);
      end

      run_random_phase(0, 0);
      run_random_phase(52, 0);
      run_random_phase(0, 52);
      run_random_phase(16, 16);

      // drain
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaited_reports.size() == 0) begin
         $display("h264_sps_pps_locator_core_tb passed");
      end else begin
         $display("h264_sps_pps_locator_core_tb failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/hspl_pkg.sv
hw/rtl/hspl_scan.sv
hw/rtl/hspl_fmt.sv
hw/rtl/h264_sps_pps_locator_core.sv
verif/h264_sps_pps_locator_core_tb.sv
